### rtl/m31dp_pkg.sv
// Package for the Mersenne-31 streaming dot product.
// Holds the modulus and field widths shared by the reduction unit and the top level.
// No dependencies.
`timescale 1ns / 1ps

package m31dp_pkg;

  localparam int unsigned ElemWidth    = 32;
  localparam int unsigned ProdWidth    = 2 * ElemWidth;
  localparam int unsigned ResWidth     = 31;
  localparam int unsigned ResTdataBits = 32;

  localparam logic [ResWidth-1:0] ModulusP = {ResWidth{1'b1}};

endpackage

### rtl/mod_mersenne31_dot_product.sv
// Top level of the streaming inner product modulo 2^31-1.
// Depends on m31dp_pkg and m31dp_reduce.
`timescale 1ns / 1ps

// Takes one pair of 32-bit elements per cycle on the slave stream and gives the inner
// product modulo 2^31-1 (in 0..2^31-2) on the master stream after the pair marked by
// tlast. A pair passes an input register, a 32x32 multiplier stage and a folding
// reduction stage, then is added into the accumulator; the sum that takes in the last
// pair is registered in the output register. The accumulator's modular add is the only
// loop, so pairs may follow each other in every cycle. Intake pauses only while a
// result waits in the output register and the next last pair is ready to finish.
module mod_mersenne31_dot_product (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] a_value, [63:32] b_value
  input  logic        s_tlast,   // last_element
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [m31dp_pkg::ResTdataBits-1:0] m_tdata    // [30:0] dot_residue, [31] zero
);

  logic                                   advance;
  logic                                   stall;

  logic                                   v1;
  logic [m31dp_pkg::ElemWidth-1:0]        a1;
  logic [m31dp_pkg::ElemWidth-1:0]        b1;
  logic                                   last1;

  logic                                   v2;
  logic [m31dp_pkg::ProdWidth-1:0]        prod2;
  logic                                   last2;

  logic                                   v3;
  logic [m31dp_pkg::ResWidth-1:0]         res3;
  logic                                   last3;

  logic [m31dp_pkg::ResWidth-1:0]         residue;
  logic [m31dp_pkg::ResWidth-1:0]         acc;
  logic [m31dp_pkg::ResWidth:0]           sum_raw;
  logic [m31dp_pkg::ResWidth:0]           sum_sub;
  logic [m31dp_pkg::ResWidth-1:0]         sum;
  logic                                   consume;

  logic                                   out_valid;
  logic [m31dp_pkg::ResWidth-1:0]         out_data;

  // hold the whole pipe only when a finishing pair meets a full output register that the sink does not take
  assign stall    = v3 && last3 && out_valid && !m_tready;
  assign advance  = !stall;
  assign s_tready = advance;
  assign consume  = v3 && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a1    <= s_tdata[m31dp_pkg::ElemWidth-1:0];
      b1    <= s_tdata[2*m31dp_pkg::ElemWidth-1:m31dp_pkg::ElemWidth];
      last1 <= s_tlast;
      prod2 <= {{m31dp_pkg::ElemWidth{1'b0}}, a1} * {{m31dp_pkg::ElemWidth{1'b0}}, b1};
      last2 <= last1;
      res3  <= residue;
      last3 <= last2;
    end
  end

  m31dp_reduce u_reduce (
    .prod    (prod2),
    .residue (residue)
  );

  assign sum_raw = {1'b0, acc} + {1'b0, res3};
  assign sum_sub = sum_raw - {1'b0, m31dp_pkg::ModulusP};

  always_comb begin
    if (sum_raw >= {1'b0, m31dp_pkg::ModulusP}) begin
      sum = sum_sub[m31dp_pkg::ResWidth-1:0];
    end else begin
      sum = sum_raw[m31dp_pkg::ResWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (consume && last3) begin
        acc       <= '0;
        out_valid <= 1'b1;
      end else begin
        if (consume) begin
          acc <= sum;
        end
        if (m_tready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && last3) begin
      out_data <= sum;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(m31dp_pkg::ResTdataBits-m31dp_pkg::ResWidth){1'b0}}, out_data};

  acc_reduced: assert property (@(posedge clk) disable iff (rst)
    acc != m31dp_pkg::ModulusP)
    else $error("accumulator left unreduced");

  out_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data != m31dp_pkg::ModulusP)
    else $error("result not reduced");

  acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (consume && last3) |=> acc == '0)
    else $error("accumulator not cleared after last pair");

  no_intake_on_stall: assert property (@(posedge clk) disable iff (rst)
    stall |-> (!s_tready && out_valid))
    else $error("intake open while result blocked");

  result_follows_last: assert property (@(posedge clk) disable iff (rst)
    (consume && last3) |=> out_valid)
    else $error("last pair gave no result");

endmodule

### rtl/m31dp_reduce.sv
// Reduction of a 64-bit product modulo 2^31-1 by folding high bits onto low bits.
// Depends on m31dp_pkg.
`timescale 1ns / 1ps

module m31dp_reduce (
  input  logic [m31dp_pkg::ProdWidth-1:0] prod,
  output logic [m31dp_pkg::ResWidth-1:0]  residue
);

  logic [m31dp_pkg::ProdWidth-m31dp_pkg::ResWidth-1:0] hi;
  logic [m31dp_pkg::ResWidth-1:0]                      lo;
  logic [m31dp_pkg::ResWidth+2:0]                      fold1;
  logic [m31dp_pkg::ResWidth:0]                        fold2;
  logic [m31dp_pkg::ResWidth:0]                        fold2_sub;

  assign hi    = prod[m31dp_pkg::ProdWidth-1:m31dp_pkg::ResWidth];
  assign lo    = prod[m31dp_pkg::ResWidth-1:0];
  // fold once: hi + lo stays below 2^34
  assign fold1 = {1'b0, hi} + {3'b000, lo};
  // fold again: at most P + 7
  assign fold2 = {1'b0, fold1[m31dp_pkg::ResWidth-1:0]}
               + {{(m31dp_pkg::ResWidth-2){1'b0}}, fold1[m31dp_pkg::ResWidth+2:m31dp_pkg::ResWidth]};
  assign fold2_sub = fold2 - {1'b0, m31dp_pkg::ModulusP};

  always_comb begin
    if (fold2 >= {1'b0, m31dp_pkg::ModulusP}) begin
      residue = fold2_sub[m31dp_pkg::ResWidth-1:0];
    end else begin
      residue = fold2[m31dp_pkg::ResWidth-1:0];
    end
  end

endmodule

### bench/mod_mersenne31_dot_product_tb.sv
// Self-checking bench for the Mersenne-31 streaming dot product.
// Predicts each residue from the accepted pairs and checks it against the master stream.
// Depends on m31dp_pkg and mod_mersenne31_dot_product.
`timescale 1ns / 1ps

module mod_mersenne31_dot_product_tb;

  localparam int unsigned CycleLimit = 300000;
  localparam logic [31:0] PrimeWord  = {1'b0, m31dp_pkg::ModulusP};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [63:0]         s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [31:0]         m_tdata;

  logic [m31dp_pkg::ResWidth-1:0] acc_residue = '0;
  logic [m31dp_pkg::ResWidth-1:0] residue_q[$];
  int unsigned         cycle_count = 0;
  int unsigned         fail_count = 0;
  int unsigned         pairs_sent = 0;
  int unsigned         sink_hold_left = 0;
  bit                  src_idle_on = 1'b1;
  bit                  sink_idle_on = 1'b1;

  mod_mersenne31_dot_product u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [m31dp_pkg::ResWidth-1:0] m31_mul(input logic [31:0] x,
                                                             input logic [31:0] y);
    logic [63:0] prod;
    logic [63:0] reduced;
    prod    = {32'b0, x} * {32'b0, y};
    reduced = prod % {32'b0, PrimeWord};
    return reduced[m31dp_pkg::ResWidth-1:0];
  endfunction

  function automatic logic [m31dp_pkg::ResWidth-1:0] m31_add(
      input logic [m31dp_pkg::ResWidth-1:0] x,
      input logic [m31dp_pkg::ResWidth-1:0] y);
    logic [31:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= PrimeWord) s = s - PrimeWord;
    return s[m31dp_pkg::ResWidth-1:0];
  endfunction

  function automatic logic [31:0] pick_elem();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return PrimeWord - 32'd1;
      3: return PrimeWord;
      4: return PrimeWord + 32'd1;
      5: return 32'hFFFF_FFFF;
      6: return 32'h8000_0000;
      7: return 32'hFFFF_0000 | $urandom_range(65535);
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h, cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  task automatic accumulate_pair(input logic [31:0] a, input logic [31:0] b, input logic last);
    logic [m31dp_pkg::ResWidth-1:0] sum;
    sum = m31_add(acc_residue, m31_mul(a, b));
    if (last) begin
      residue_q.push_back(sum);
      acc_residue = '0;
    end else begin
      acc_residue = sum;
    end
  endtask

  // Offer one pair and hold it until the transfer.
  task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input logic last);
    while (src_idle_on && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    accumulate_pair(a, b, last);
    pairs_sent++;
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (residue_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (sink_hold_left != 0) sink_hold_left <= sink_hold_left - 1;
  end

  always @(posedge clk) begin
    logic [m31dp_pkg::ResWidth-1:0] want;
    if (m_tvalid && m_tready) begin
      if (residue_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 32'h0);
      end else begin
        want = residue_q.pop_front();
        if (m_tdata[m31dp_pkg::ResWidth-1:0] !== want)
          report_mismatch("dot_residue", {1'b0, m_tdata[m31dp_pkg::ResWidth-1:0]},
                          {1'b0, want});
        if (m_tdata[31] !== 1'b0) report_mismatch("tdata pad bit", m_tdata, {1'b0, want});
      end
    end
    if (sink_hold_left != 0) m_tready <= 1'b0;
    else if (sink_idle_on) m_tready <= ($urandom_range(99) >= 32);
    else m_tready <= 1'b1;
  end

  task automatic test_single_pairs();
    send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_pair(32'h0000_0001, 32'h0000_0001, 1'b1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_pair(PrimeWord, 32'h0000_0005, 1'b1);
    send_pair(PrimeWord + 32'd1, PrimeWord + 32'd1, 1'b1);
    send_pair(PrimeWord - 32'd1, PrimeWord - 32'd1, 1'b1);
    send_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
  endtask

  task automatic test_accumulator_wrap();
    repeat (5) send_pair(PrimeWord - 32'd1, 32'h0000_0001, 1'b0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    repeat (3) send_pair(PrimeWord, 32'hFFFF_FFFF, 1'b0);
    send_pair(32'h7FFF_FFFF, PrimeWord - 32'd1, 1'b1);
  endtask

  task automatic test_random_vectors(input int unsigned n_pairs);
    int unsigned target;
    int unsigned len;
    target = pairs_sent + n_pairs;
    while (pairs_sent < target) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(64, 17) : $urandom_range(12, 1);
      for (int unsigned i = 0; i < len; i++) send_pair(pick_elem(), pick_elem(), i == len - 1);
    end
  endtask

  task automatic test_no_idle_stretch(input int unsigned n_pairs);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_random_vectors(n_pairs);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Stall the sink while short vectors keep coming, so intake backs up.
  task automatic test_backpressure();
    src_idle_on = 1'b0;
    sink_hold_left <= 160;
    repeat (20) send_pair(pick_elem(), pick_elem(), 1'($urandom_range(1)));
    repeat (20) send_pair($urandom, $urandom, 1'b1);
    src_idle_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_single_pairs();
    test_accumulator_wrap();
    wait_for_drain();
    test_random_vectors(700);
    wait_for_drain();
    test_no_idle_stretch(300);
    test_backpressure();
    wait_for_drain();
    test_random_vectors(350);
    wait_for_drain();
    repeat (16) @(posedge clk);
    if (residue_q.size() != 0) report_mismatch("results missing", 32'h0, residue_q.size());
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
